// ===== sv/aip_pkg.sv =====
// aip_pkg: shared types and character constants for the ascii integer parser
// used by aip_step and ascii_integer_parser_core; depends on nothing
`default_nettype none

package aip_pkg;

  localparam int unsigned OFF_W = 12;

  typedef enum logic [5:0] {
    PH_DONE   = 6'b000001,
    PH_LEAD   = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_XPEND  = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] acc;
    logic        neg;
    logic        seen;
    logic        ovf;
  } parse_state_t;

  typedef struct packed {
    logic [63:0]      value;
    logic             converted;
    logic [OFF_W-1:0] end_offset;
    logic             wrapped;
  } result_t;

  localparam logic       CFG_RADIX = 1'b0;
  localparam logic       CFG_MINUS = 1'b1;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_F_UP   = 8'h46;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_F_LO   = 8'h66;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [63:0] DEC_SAFE = 64'h1999999999999999;

endpackage

`default_nettype wire

// ===== sv/ascii_integer_parser_core.sv =====
// ascii_integer_parser_core: top level of the streaming ascii integer parser
// depends on aip_pkg and aip_step
//
// usage: characters of a zero-terminated string enter one per item on the in_ channel
// (valid/ready); in_string_start marks the first character and restarts the parse.
// leading whitespace, an optional sign and, in hex mode, a 0x prefix are taken, then
// digits are accumulated modulo 2^64. the first character not accepted produces one
// result item on the out_ channel: value, converted flag, end offset and wrap flag.
// later characters are dropped until the next string start.
// an accepted item is held in the input register, and the parse step between it and
// the result register loads any result it produces. throughput: one item per cycle,
// set by the single parse step, unless a waiting result stalls the input register.
// stall: while a result waits on out_ready, the input register still takes one item
// and keeps absorbing items that produce no result; only an item that would produce
// a second result holds in_ready low.
// reset: rst_n (synchronous) clears the parse state to waiting for a string start
// and sets radix_sixteen to 0, allow_minus to 1. cfg_ writes take effect next cycle.
`default_nettype none

module ascii_integer_parser_core #(
  parameter int unsigned OFFSET_LIMIT = 4095
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_string_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_parsed_value,
  output logic             out_converted,
  output logic [11:0]      out_end_offset,
  output logic             out_wrapped,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic        cfg_wdata
);

  localparam int unsigned POS_W = $clog2(OFFSET_LIMIT + 1);

  logic                  radix_r;
  logic                  minus_r;
  logic                  s1_valid_r;
  logic [7:0]            s1_char_r;
  logic                  s1_start_r;
  aip_pkg::parse_state_t st_r;
  aip_pkg::parse_state_t st_nxt;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      pos_nxt;
  logic                  emit;
  aip_pkg::result_t      res;
  aip_pkg::result_t      out_r;
  logic                  out_valid_r;
  logic                  out_free;
  logic                  s1_adv;

  aip_step #(
    .OFFSET_LIMIT (OFFSET_LIMIT),
    .POS_W        (POS_W)
  ) u_step (
    .st            (st_r),
    .pos           (pos_r),
    .char_code     (s1_char_r),
    .string_start  (s1_start_r),
    .radix_sixteen (radix_r),
    .allow_minus   (minus_r),
    .st_nxt        (st_nxt),
    .pos_nxt       (pos_nxt),
    .emit          (emit),
    .res           (res)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= 1'b0;
      minus_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        aip_pkg::CFG_RADIX: radix_r <= cfg_wdata;
        aip_pkg::CFG_MINUS: minus_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r  <= in_char_code;
      s1_start_r <= in_string_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= aip_pkg::PH_DONE;
      st_r.acc   <= 64'd0;
      st_r.neg   <= 1'b0;
      st_r.seen  <= 1'b0;
      st_r.ovf   <= 1'b0;
      pos_r      <= '0;
    end else if (s1_adv) begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = out_r.value;
  assign out_converted    = out_r.converted;
  assign out_end_offset   = out_r.end_offset;
  assign out_wrapped      = out_r.wrapped;

  a_no_digit_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.converted |-> out_r.end_offset == '0 && out_r.value == 64'd0)
    else $error("result without digits carries offset or value");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit |=> st_r.phase == aip_pkg::PH_DONE)
    else $error("parse not finished after result");

  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(OFFSET_LIMIT))
    else $error("character position above limit");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> out_valid_r && !out_ready && emit)
    else $error("input stage held without a pending result");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !$past(s1_adv && emit) && $past(rst_n) |-> !$rose(out_valid_r))
    else $error("result appeared without a finished parse");

endmodule

`default_nettype wire

// ===== sv/aip_step.sv =====
// aip_step: one parse step, classifies a character and computes next state and result
// depends on aip_pkg
`default_nettype none

module aip_step #(
  parameter int unsigned OFFSET_LIMIT = 4095,
  parameter int unsigned POS_W        = 12
) (
  input  aip_pkg::parse_state_t st,
  input  logic [POS_W-1:0]      pos,
  input  logic [7:0]            char_code,
  input  logic                  string_start,
  input  logic                  radix_sixteen,
  input  logic                  allow_minus,
  output aip_pkg::parse_state_t st_nxt,
  output logic [POS_W-1:0]      pos_nxt,
  output logic                  emit,
  output aip_pkg::result_t      res
);

  localparam logic [POS_W-1:0] POS_LIM = POS_W'(OFFSET_LIMIT);
  localparam int unsigned      EXT_W   = POS_W + aip_pkg::OFF_W;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    pos_inc = (p == POS_LIM) ? p : p + 1'b1;
  endfunction

  aip_pkg::parse_state_t st_e;
  logic [POS_W-1:0]      pos_e;
  logic [POS_W-1:0]      cur;
  logic [POS_W-1:0]      end_idx;
  logic [EXT_W-1:0]      end_ext;
  logic                  is_blank;
  logic                  is_x;
  logic                  is_dig;
  logic [3:0]            dval;
  logic [7:0]            dsub;
  logic [63:0]           acc_new;
  logic                  ovf_new;
  logic                  fall;
  logic                  lead_zero;

  // digit classify
  always_comb begin
    is_dig = 1'b0;
    dsub   = 8'h00;
    if (char_code >= aip_pkg::CH_ZERO && char_code <= aip_pkg::CH_NINE) begin
      is_dig = 1'b1;
      dsub   = char_code - aip_pkg::CH_ZERO;
    end else if (radix_sixteen && char_code >= aip_pkg::CH_A_UP &&
                 char_code <= aip_pkg::CH_F_UP) begin
      is_dig = 1'b1;
      dsub   = char_code - aip_pkg::CH_A_UP + 8'd10;
    end else if (radix_sixteen && char_code >= aip_pkg::CH_A_LO &&
                 char_code <= aip_pkg::CH_F_LO) begin
      is_dig = 1'b1;
      dsub   = char_code - aip_pkg::CH_A_LO + 8'd10;
    end
    dval = dsub[3:0];
  end

  assign is_blank = char_code inside {aip_pkg::CH_SPACE, aip_pkg::CH_TAB, aip_pkg::CH_NL,
                                      aip_pkg::CH_VT, aip_pkg::CH_FF, aip_pkg::CH_CR};
  assign is_x     = (char_code == aip_pkg::CH_X_LO) || (char_code == aip_pkg::CH_X_UP);

  // effective state after an optional restart
  always_comb begin
    if (string_start) begin
      st_e.phase = aip_pkg::PH_LEAD;
      st_e.acc   = 64'd0;
      st_e.neg   = 1'b0;
      st_e.seen  = 1'b0;
      st_e.ovf   = 1'b0;
      pos_e      = '0;
      cur        = '0;
    end else begin
      st_e  = st;
      pos_e = pos;
      cur   = (st.phase == aip_pkg::PH_XPEND) ? pos_inc(pos) : pos;
    end
  end

  // shift-add accumulate
  always_comb begin
    if (radix_sixteen) begin
      ovf_new = st_e.ovf | (st_e.acc[63:60] != 4'd0);
      acc_new = {st_e.acc[59:0], dval};
    end else begin
      ovf_new = st_e.ovf | (st_e.acc > aip_pkg::DEC_SAFE) |
                ((st_e.acc == aip_pkg::DEC_SAFE) && (dval > 4'd5));
      acc_new = {st_e.acc[60:0], 3'b000} + {st_e.acc[62:0], 1'b0} + {60'd0, dval};
    end
  end

  assign lead_zero = radix_sixteen && (char_code == aip_pkg::CH_ZERO) &&
                     ((st_e.phase == aip_pkg::PH_LEAD) || (st_e.phase == aip_pkg::PH_SIGNED));

  always_comb begin
    st_nxt  = st_e;
    pos_nxt = pos_e;
    emit    = 1'b0;
    end_idx = cur;
    fall    = 1'b0;
    if (string_start || st.phase != aip_pkg::PH_DONE) begin
      unique case (st_e.phase)
        aip_pkg::PH_LEAD: begin
          if (is_blank) begin
            pos_nxt = pos_inc(cur);
          end else if (char_code == aip_pkg::CH_PLUS) begin
            st_nxt.phase = aip_pkg::PH_SIGNED;
            pos_nxt      = pos_inc(cur);
          end else if (char_code == aip_pkg::CH_MINUS && allow_minus) begin
            st_nxt.phase = aip_pkg::PH_SIGNED;
            st_nxt.neg   = 1'b1;
            pos_nxt      = pos_inc(cur);
          end else begin
            fall = 1'b1;
          end
        end
        aip_pkg::PH_ZERO: begin
          if (radix_sixteen && is_x) begin
            st_nxt.phase = aip_pkg::PH_XPEND;
            pos_nxt      = cur;
          end else begin
            fall = 1'b1;
          end
        end
        aip_pkg::PH_XPEND: begin
          if (!is_dig) begin
            emit         = 1'b1;
            end_idx      = pos_e;
            st_nxt.phase = aip_pkg::PH_DONE;
          end else begin
            st_nxt.acc   = acc_new;
            st_nxt.ovf   = ovf_new;
            st_nxt.seen  = 1'b1;
            st_nxt.phase = aip_pkg::PH_DIGITS;
            pos_nxt      = pos_inc(cur);
          end
        end
        default: begin
          fall = 1'b1;
        end
      endcase
      if (fall) begin
        if (!is_dig) begin
          emit         = 1'b1;
          st_nxt.phase = aip_pkg::PH_DONE;
        end else begin
          st_nxt.acc   = acc_new;
          st_nxt.ovf   = ovf_new;
          st_nxt.seen  = 1'b1;
          st_nxt.phase = lead_zero ? aip_pkg::PH_ZERO : aip_pkg::PH_DIGITS;
          pos_nxt      = pos_inc(cur);
        end
      end
    end
  end

  assign end_ext       = {{aip_pkg::OFF_W{1'b0}}, end_idx};
  assign res.value     = st_e.neg ? (64'd0 - st_e.acc) : st_e.acc;
  assign res.converted = st_e.seen;
  assign res.end_offset = st_e.seen ? end_ext[aip_pkg::OFF_W-1:0] : '0;
  assign res.wrapped   = st_e.ovf;

endmodule

`default_nettype wire
